@@ design/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the interval timer: item kinds, register
// offsets and the control and view records passed to each channel.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Item kinds carried in the low bits of the input tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Fixed part of the ID register, bits 31:12
    localparam logic [19:0] ID_VALUE = 20'h03031;

    // Global register offsets
    localparam logic [7:0] OFF_ID      = 8'h00;
    localparam logic [7:0] OFF_CFG     = 8'h10;
    localparam logic [7:0] OFF_INT_EN  = 8'h14;
    localparam logic [7:0] OFF_INT_STA = 8'h18;
    localparam logic [7:0] OFF_CH_EN   = 8'h1C;

    // Per-channel block: base 0x20, 16 bytes per channel
    localparam logic [3:0] CH_BASE_ROW = 4'h2;
    localparam logic [3:0] OFF_CTRL    = 4'h0;
    localparam logic [3:0] OFF_RELOAD  = 4'h4;
    localparam logic [3:0] OFF_COUNT   = 4'h8;

    // Control register: bits 2:0 mode, bit 3 clock source
    localparam int CTRL_W   = 4;
    localparam int CLK_BIT  = 3;
    // Spacing of a channel's bit in the enable and status registers
    localparam int BIT_STEP = 4;

    // Input item layout
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int CCNT_W  = 3;

    // Command from the register decode to one channel
    typedef struct packed {
        logic              wr_ctrl;
        logic              wr_reload;
        logic              start;
        logic              run;
        logic              tick;
        logic              tick_source;
        logic [DATA_W-1:0] wdata;
    } t_chan_cmd;

    // Readable state of one channel
    typedef struct packed {
        logic [CTRL_W-1:0] ctrl;
        logic [DATA_W-1:0] reload;
        logic [DATA_W-1:0] count;
    } t_chan_view;

endpackage

@@ design/programmable_interval_timer_top.sv @@
// ----------------------------------------------------------------------------
// programmable_interval_timer_top
// Multi-channel 32-bit interval timer driven by a stream of bus reads,
// bus writes and clock ticks, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the item kind (read, write, tick) and the
//   tick clock kind; tdata carries the register byte offset and write data.
//   Output stream: one transaction per input item with the read data (zero
//   for writes and ticks) and the interrupt flag as it stands after the item.
//   Configuration channel: writes the channel count reported in the CFG register;
//   always ready; the user must use it only while the block is idle (not enforced).
// Pipeline and throughput:
//   An item is accepted into the input register, executed by the decode and
//   channel update logic once the output register is free or draining, and
//   registered as a result in the output register. One item per cycle is
//   sustained while the receiver keeps up; every channel updates in parallel on a tick.
// Reset and stall:
//   Reset clears all timer registers, the interrupt bits and both stages;
//   the reported channel count returns to 4. When the receiver stalls, the
//   result stays in the output register, one more item waits in the input
//   register, and then the input side stops accepting.
// ----------------------------------------------------------------------------
module programmable_interval_timer_top #(
    parameter int CHANNELS = 4,
    parameter int REVISION = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,  // addr[7:0], wdata[39:8]
    input  logic [2:0]                 s_axis_tuser,  // op[1:0], tick_source[2]
    // Output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [39:0]                m_axis_tdata,  // rdata[31:0], irq[32], zero pad
    // Configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pit_pkg::CCNT_W-1:0] i_cfg_data
);
    import pit_pkg::*;

    logic               r_in_valid;
    logic [OP_W-1:0]    r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_wdata;
    logic               r_tick_source;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_rdata;
    logic               r_irq;
    logic               w_advance;
    logic               w_fire;
    logic               w_accept;
    logic [DATA_W-1:0]  w_rdata;
    logic               w_irq;

    // Advance when the output register is free or being drained
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign o_cfg_ready   = 1'b1;

    // Hold stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture input payload and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op          <= s_axis_tuser[1:0];
            r_tick_source <= s_axis_tuser[2];
            r_addr        <= s_axis_tdata[7:0];
            r_wdata       <= s_axis_tdata[39:8];
        end
        if (w_fire) begin
            r_rdata <= w_rdata;
            r_irq   <= w_irq;
        end
    end

    pit_core #(
        .CHANNELS (CHANNELS),
        .REVISION (REVISION)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_fire        (w_fire),
        .i_op          (r_op),
        .i_addr        (r_addr),
        .i_wdata       (r_wdata),
        .i_tick_source (r_tick_source),
        .o_rdata       (w_rdata),
        .o_irq         (w_irq)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_irq, r_rdata};

endmodule

@@ design/pit_chan.sv @@
// ----------------------------------------------------------------------------
// pit_chan
// One timer channel: control and reload registers and a 32-bit down-counter
// that reloads and flags a wrap when a matching tick finds it at zero.
// ----------------------------------------------------------------------------
module pit_chan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pit_pkg::t_chan_cmd  i_cmd,
    output pit_pkg::t_chan_view o_view,
    output logic               o_wrap
);
    import pit_pkg::*;

    logic [CTRL_W-1:0] r_ctrl;
    logic [DATA_W-1:0] r_reload;
    logic [DATA_W-1:0] r_count;
    logic [DATA_W-1:0] n_count;
    logic              w_count_tick;

    // Count only on ticks of the selected clock while running
    assign w_count_tick = i_cmd.tick && i_cmd.run && (r_ctrl[CLK_BIT] == i_cmd.tick_source);
    assign o_wrap       = w_count_tick && (r_count == '0);

    // Next counter value: load on start, reload on wrap, decrement on other counting ticks, else hold
    always_comb begin
        n_count = r_count;
        if (i_cmd.start) begin
            n_count = r_reload;
        end else if (w_count_tick) begin
            if (r_count == '0) begin
                n_count = r_reload;
            end else begin
                n_count = r_count - DATA_W'(1);
            end
        end
    end

    // Hold channel registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_reload <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.wr_ctrl) begin
                r_ctrl <= i_cmd.wdata[CTRL_W-1:0];
            end
            if (i_cmd.wr_reload) begin
                r_reload <= i_cmd.wdata;
            end
            r_count <= n_count;
        end
    end

    assign o_view.ctrl   = r_ctrl;
    assign o_view.reload = r_reload;
    assign o_view.count  = r_count;

endmodule

@@ design/pit_core.sv @@
// ----------------------------------------------------------------------------
// pit_core
// Register decode, global enable and status bits, read mux and interrupt
// flag. Executes one item per cycle on the fire strobe.
// ----------------------------------------------------------------------------
module pit_core #(
    parameter int CHANNELS = 4,
    parameter int REVISION = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pit_pkg::CCNT_W-1:0] i_cfg_data,
    input  logic                       i_fire,
    input  logic [pit_pkg::OP_W-1:0]   i_op,
    input  logic [pit_pkg::ADDR_W-1:0] i_addr,
    input  logic [pit_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_tick_source,
    output logic [pit_pkg::DATA_W-1:0] o_rdata,
    output logic                       o_irq
);
    import pit_pkg::*;

    logic [CCNT_W-1:0]   r_channel_count;
    logic [CHANNELS-1:0] r_irq_en;
    logic [CHANNELS-1:0] r_status;
    logic [CHANNELS-1:0] r_run;
    logic [CHANNELS-1:0] n_irq_en;
    logic [CHANNELS-1:0] n_status;
    logic [CHANNELS-1:0] n_run;
    logic [CHANNELS-1:0] w_wrap;
    logic [CHANNELS-1:0] w_new_bits;
    logic                w_rd;
    logic                w_wr;
    logic                w_tick;
    logic [DATA_W-1:0]   w_irq_en_word;
    logic [DATA_W-1:0]   w_status_word;
    logic [DATA_W-1:0]   w_run_word;
    t_chan_view          w_view [CHANNELS];

    // Decode the item kind
    always_comb begin
        w_rd   = 1'b0;
        w_wr   = 1'b0;
        w_tick = 1'b0;
        case (t_op'(i_op))
            OP_READ:  w_rd   = i_fire;
            OP_WRITE: w_wr   = i_fire;
            OP_TICK:  w_tick = i_fire;
            default:  ;
        endcase
    end

    // Gather each channel's bit from the written word, and spread the
    // stored bits back to positions 4c for reads
    always_comb begin
        w_irq_en_word = '0;
        w_status_word = '0;
        w_run_word    = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_new_bits[c]                = i_wdata[BIT_STEP*c];
            w_irq_en_word[BIT_STEP*c]    = r_irq_en[c];
            w_status_word[BIT_STEP*c]    = r_status[c];
            w_run_word[BIT_STEP*c]       = r_run[c];
        end
    end

    // Channel instances with their write strobes
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        logic      w_hit;
        t_chan_cmd w_cmd;

        assign w_hit             = (i_addr[7:4] == CH_BASE_ROW + 4'(g));
        assign w_cmd.wr_ctrl     = w_wr && w_hit && (i_addr[3:0] == OFF_CTRL);
        assign w_cmd.wr_reload   = w_wr && w_hit && (i_addr[3:0] == OFF_RELOAD);
        assign w_cmd.start       = w_wr && (i_addr == OFF_CH_EN) && w_new_bits[g] && !r_run[g];
        assign w_cmd.run         = r_run[g];
        assign w_cmd.tick        = w_tick;
        assign w_cmd.tick_source = i_tick_source;
        assign w_cmd.wdata       = i_wdata;

        pit_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .o_view  (w_view[g]),
            .o_wrap  (w_wrap[g])
        );
    end

    // Next values of the global bit registers
    always_comb begin
        n_irq_en = r_irq_en;
        n_run    = r_run;
        n_status = r_status | w_wrap;
        if (w_wr && i_addr == OFF_INT_EN) begin
            n_irq_en = w_new_bits;
        end
        if (w_wr && i_addr == OFF_INT_STA) begin
            n_status = r_status & ~w_new_bits;
        end
        if (w_wr && i_addr == OFF_CH_EN) begin
            n_run = w_new_bits;
        end
    end

    // Hold global registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CCNT_W'(4);
            r_irq_en        <= '0;
            r_status        <= '0;
            r_run           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_channel_count <= i_cfg_data;
            end
            r_irq_en <= n_irq_en;
            r_status <= n_status;
            r_run    <= n_run;
        end
    end

    // Read mux over current state
    always_comb begin
        o_rdata = '0;
        if (w_rd) begin
            case (i_addr)
                OFF_ID:      o_rdata = {ID_VALUE, 12'(REVISION)};
                OFF_CFG:     o_rdata = DATA_W'(r_channel_count);
                OFF_INT_EN:  o_rdata = w_irq_en_word;
                OFF_INT_STA: o_rdata = w_status_word;
                OFF_CH_EN:   o_rdata = w_run_word;
                default: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (i_addr[7:4] == CH_BASE_ROW + 4'(c)) begin
                            case (i_addr[3:0])
                                OFF_CTRL:   o_rdata = DATA_W'(w_view[c].ctrl);
                                OFF_RELOAD: o_rdata = w_view[c].reload;
                                OFF_COUNT:  o_rdata = w_view[c].count;
                                default:    ;
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    // Interrupt line after the item
    assign o_irq = |(n_status & n_irq_en);

endmodule
